// ----- rtl/rlpf_pkg.sv -----
// Types, constants and the duty scaling function for the RGB LED pattern fader.
// No dependencies; the top level imports this package.
package rlpf_pkg;

    localparam int MAX_STEPS   = 16;
    localparam int NUM_CH      = 3;
    localparam int TABLE_DEPTH = NUM_CH * MAX_STEPS;
    localparam int IDX_W       = 6;
    localparam int LVL_W       = 7;
    localparam int STEP_W      = 5;
    localparam int SCALE_W     = 24;
    localparam int DUTY_W      = 16;
    localparam int PROD_W      = SCALE_W + LVL_W;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam logic [STEP_W-1:0] STEPS_LIMIT = STEP_W'(MAX_STEPS);
    localparam logic [LVL_W-1:0]  FLASH_LEVEL = LVL_W'(50);
    localparam logic [DUTY_W-1:0] PWM_PERIOD  = DUTY_W'(1000);

    // duty = floor(prod / 25600) = floor((prod >> 10) / 25)
    localparam int                RECIP_W     = 22;
    localparam int                RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] RECIP_25   = RECIP_W'(2684355);
    localparam logic [PROD_W-1:0] SAT_LIMIT   = PROD_W'(1677721600);

    localparam logic [0:0] CFG_SCALE = 1'b0;
    localparam logic [0:0] CFG_STEPS = 1'b1;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_FLASH = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        COL_RED   = 2'd0,
        COL_GREEN = 2'd1,
        COL_BLUE  = 2'd2,
        COL_WHITE = 2'd3
    } t_color;

    // Saturating floor(prod / 25600) via reciprocal multiply, exact below SAT_LIMIT.
    function automatic logic [DUTY_W-1:0] duty_of(input logic [PROD_W-1:0] prod);
        logic [PROD_W-11:0]          y;
        logic [PROD_W-10+RECIP_W-1:0] q;
        y = prod[PROD_W-1:10];
        q = (PROD_W-10+RECIP_W)'(y) * (PROD_W-10+RECIP_W)'(RECIP_25);
        if (prod >= SAT_LIMIT) begin
            return '1;
        end
        return q[RECIP_SHIFT+DUTY_W-1:RECIP_SHIFT];
    endfunction

endpackage

// ----- rtl/rlpf_ram.sv -----
// Generic RAM: one write port, two registered read ports, read-before-write.
// No dependencies.
module rlpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- rtl/rgb_led_pattern_fader.sv -----
// RGB LED pattern fader top level; uses rlpf_pkg and rlpf_ram.
//
// Input channel (i_valid/o_ready) carries one word per action: tick, pattern
// table write or flash request. Only a tick produces an output word on the
// o_valid/i_ready channel: three PWM compare values and the step index.
// Configuration (scale, steps per color) goes through the i_cfg_* port; the
// user must write it with no tick in flight, which the block does not enforce.
//
// Throughput: one word per cycle while o_ready is high. The pattern table
// is held in three RAM copies, each read every cycle at the current step
// and at the step that follows it, so a tick that advances the step does
// not stall the next one. A tick's state update and scale product are
// registered in stage A and the divide-by-25600 multiply in stage B, whose
// valid flag drives o_valid.
// Reset clears the step, levels, pending flash and config registers; the
// table is undefined until written. o_ready is held low after reset, and
// in the cycle after each config write, while the table read is refetched.
// When the receiver stalls, the two pipeline stages hold; o_ready drops
// when both are full, and while r_hold is set.
module rgb_led_pattern_fader
    import rlpf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_action,
    input  logic [IDX_W-1:0]   i_entry_index,
    input  logic [LVL_W-1:0]   i_entry_value,
    input  logic [1:0]         i_flash_color,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [DUTY_W-1:0]  o_red_duty,
    output logic [DUTY_W-1:0]  o_green_duty,
    output logic [DUTY_W-1:0]  o_blue_duty,
    output logic [STEP_W-1:0]  o_step_index,
    input  logic               i_cfg_we,
    input  logic [0:0]         i_cfg_index,
    input  logic [SCALE_W-1:0] i_cfg_wdata
);

    // configuration and control state
    logic [SCALE_W-1:0] r_scale;
    logic [STEP_W-1:0]  r_steps_cfg;
    logic               r_hold;
    logic [STEP_W-1:0]  r_step;
    logic [LVL_W-1:0]   r_lvl [NUM_CH];
    logic               r_flash_pend;
    t_color             r_flash_col;

    // table read bookkeeping
    logic               r_adv;
    logic               r_wr_valid;
    logic [IDX_W-1:0]   r_wr_addr;
    logic [LVL_W-1:0]   r_wr_data;
    logic [IDX_W-1:0]   r_addr_a [NUM_CH];
    logic [IDX_W-1:0]   r_addr_b [NUM_CH];
    logic [LVL_W-1:0]   w_rd_a [NUM_CH];
    logic [LVL_W-1:0]   w_rd_b [NUM_CH];

    // pipeline stages
    logic               r_a_valid;
    logic               r_a_flash;
    logic [NUM_CH-1:0]  r_a_mask;
    logic [STEP_W-1:0]  r_a_step;
    logic [PROD_W-1:0]  r_a_prod [NUM_CH];
    logic               r_b_valid;
    logic [DUTY_W-1:0]  r_b_duty [NUM_CH];
    logic [STEP_W-1:0]  r_b_step;

    // combinational
    logic               in_acc;
    logic               is_tick;
    logic               is_write;
    logic               is_flash;
    logic               tick_acc;
    logic               wr_en;
    logic               pipe_adv;
    logic [STEP_W-1:0]  n_eff;
    logic [STEP_W-1:0]  cur_e;
    logic [STEP_W-1:0]  nxt_e;
    logic [IDX_W-1:0]   base [NUM_CH];
    logic [IDX_W-1:0]   n_addr_a [NUM_CH];
    logic [IDX_W-1:0]   n_addr_b [NUM_CH];
    logic [LVL_W-1:0]   tgt [NUM_CH];
    logic [NUM_CH-1:0]  hit;
    logic [LVL_W-1:0]   n_fade [NUM_CH];
    logic [LVL_W-1:0]   n_lvl [NUM_CH];
    logic [NUM_CH-1:0]  n_mask;
    logic [STEP_W-1:0]  n_step;

    always_comb begin
        is_tick  = 1'b0;
        is_write = 1'b0;
        is_flash = 1'b0;
        case (t_action'(i_action))
            ACT_TICK:  is_tick  = 1'b1;
            ACT_WRITE: is_write = 1'b1;
            ACT_FLASH: is_flash = 1'b1;
            default:   is_tick  = 1'b0;
        endcase
    end

    assign pipe_adv = !r_b_valid || i_ready;
    assign o_ready  = i_rst_n && !r_hold && (!r_a_valid || pipe_adv);
    assign in_acc   = i_valid && o_ready;
    assign tick_acc = in_acc && is_tick;
    assign wr_en    = in_acc && is_write && (i_entry_index < IDX_W'(TABLE_DEPTH));

    // effective step now and the one after it; both are prefetched
    always_comb begin
        n_eff = (r_steps_cfg > STEPS_LIMIT) ? STEPS_LIMIT : r_steps_cfg;
        cur_e = (r_step >= n_eff) ? '0 : r_step;
        nxt_e = ((cur_e + STEP_W'(1)) >= n_eff) ? '0 : cur_e + STEP_W'(1);
        base[CH_RED]   = '0;
        base[CH_GREEN] = IDX_W'(n_eff);
        base[CH_BLUE]  = {n_eff, 1'b0};
        for (int c = 0; c < NUM_CH; c++) begin
            n_addr_a[c] = base[c] + IDX_W'(cur_e);
            n_addr_b[c] = base[c] + IDX_W'(nxt_e);
        end
    end

    for (genvar c = 0; c < NUM_CH; c++) begin : g_table
        rlpf_ram #(
            .WIDTH (LVL_W),
            .DEPTH (TABLE_DEPTH)
        ) u_ram (
            .i_clk     (i_clk),
            .i_we      (wr_en),
            .i_waddr   (i_entry_index),
            .i_wdata   (i_entry_value),
            .i_raddr_a (n_addr_a[c]),
            .i_raddr_b (n_addr_b[c]),
            .o_rdata_a (w_rd_a[c]),
            .o_rdata_b (w_rd_b[c])
        );
    end

    // pick the prefetched target, forward a write made in the previous cycle
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (r_wr_valid && (r_wr_addr == (r_adv ? r_addr_b[c] : r_addr_a[c]))) begin
                tgt[c] = r_wr_data;
            end else begin
                tgt[c] = r_adv ? w_rd_b[c] : w_rd_a[c];
            end
            hit[c] = (r_lvl[c] == tgt[c]);
            if (r_lvl[c] < tgt[c]) begin
                n_fade[c] = r_lvl[c] + LVL_W'(1);
            end else if (r_lvl[c] > tgt[c]) begin
                n_fade[c] = r_lvl[c] - LVL_W'(1);
            end else begin
                n_fade[c] = r_lvl[c];
            end
        end
        n_step = cur_e + STEP_W'(&hit);
        n_mask[CH_RED]   = (r_flash_col == COL_RED)   || (r_flash_col == COL_WHITE);
        n_mask[CH_GREEN] = (r_flash_col == COL_GREEN) || (r_flash_col == COL_WHITE);
        n_mask[CH_BLUE]  = (r_flash_col == COL_BLUE)  || (r_flash_col == COL_WHITE);
        for (int c = 0; c < NUM_CH; c++) begin
            if (r_flash_pend) begin
                n_lvl[c] = n_mask[c] ? FLASH_LEVEL : '0;
            end else begin
                n_lvl[c] = n_fade[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale      <= '0;
            r_steps_cfg  <= '0;
            r_hold       <= 1'b1;
            r_step       <= '0;
            r_flash_pend <= 1'b0;
            r_flash_col  <= COL_RED;
            r_adv        <= 1'b0;
            r_wr_valid   <= 1'b0;
            r_a_valid    <= 1'b0;
            r_b_valid    <= 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_lvl[c] <= '0;
            end
        end else begin
            r_hold     <= i_cfg_we;
            r_adv      <= tick_acc && (&hit);
            r_wr_valid <= wr_en;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SCALE: r_scale     <= i_cfg_wdata;
                    CFG_STEPS: r_steps_cfg <= i_cfg_wdata[STEP_W-1:0];
                    default:   r_scale     <= r_scale;
                endcase
            end
            if (in_acc && is_flash) begin
                r_flash_pend <= 1'b1;
                r_flash_col  <= t_color'(i_flash_color);
            end
            if (tick_acc) begin
                r_step       <= n_step;
                r_flash_pend <= 1'b0;
                for (int c = 0; c < NUM_CH; c++) begin
                    r_lvl[c] <= n_lvl[c];
                end
            end
            if (pipe_adv) begin
                r_b_valid <= r_a_valid;
            end
            // stage A loads whenever it is empty or drains into stage B
            if (!r_a_valid || pipe_adv) begin
                r_a_valid <= tick_acc;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_wr_addr <= i_entry_index;
        r_wr_data <= i_entry_value;
        for (int c = 0; c < NUM_CH; c++) begin
            r_addr_a[c] <= n_addr_a[c];
            r_addr_b[c] <= n_addr_b[c];
        end
        if (tick_acc) begin
            r_a_flash <= r_flash_pend;
            r_a_mask  <= n_mask;
            r_a_step  <= n_step;
            for (int c = 0; c < NUM_CH; c++) begin
                r_a_prod[c] <= PROD_W'(r_scale) * PROD_W'(n_fade[c]);
            end
        end
        if (pipe_adv && r_a_valid) begin
            r_b_step <= r_a_step;
            for (int c = 0; c < NUM_CH; c++) begin
                if (r_a_flash) begin
                    r_b_duty[c] <= r_a_mask[c] ? PWM_PERIOD : '0;
                end else begin
                    r_b_duty[c] <= duty_of(r_a_prod[c]);
                end
            end
        end
    end

    assign o_valid      = r_b_valid;
    assign o_red_duty   = r_b_duty[CH_RED];
    assign o_green_duty = r_b_duty[CH_GREEN];
    assign o_blue_duty  = r_b_duty[CH_BLUE];
    assign o_step_index = r_b_step;

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEPS_LIMIT)
        else $error("step counter above step limit");

    a_cfg_refetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> !o_ready)
        else $error("word accepted before table refetch after config write");

    a_flash_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_acc && r_flash_pend) |=> (r_a_valid && r_a_flash && !r_flash_pend))
        else $error("pending flash not carried into the pipeline");

    a_flash_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_acc && r_flash_pend) |=>
            ((r_lvl[CH_RED] == FLASH_LEVEL) || (r_lvl[CH_RED] == '0)))
        else $error("red level not preset by flash");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !pipe_adv) |=> (r_a_valid && $stable(r_a_step)))
        else $error("stalled stage lost its word");

endmodule
